// File: rtl/bdm_pkg.sv
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared types, constants and helper functions for the batched divstep
// matrix unit: word widths, packing offsets, multiplier step codes and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package bdm_pkg;

    localparam int unsigned WORD_W          = 64;
    localparam int unsigned LOW_W           = 20;
    localparam int unsigned COEF_W          = 22;
    localparam int unsigned MAT_W           = 62;
    localparam int unsigned DELTA_W         = 16;
    localparam int unsigned STEPS_PER_ROUND = 20;
    localparam int unsigned ROUNDS          = 3;
    localparam int unsigned MUL_STEPS       = 4;
    localparam int unsigned PROD_W          = 55;

    localparam int unsigned STEP_CNT_W  = $clog2(STEPS_PER_ROUND);
    localparam int unsigned ROUND_CNT_W = $clog2(ROUNDS);
    localparam int unsigned MUL_CNT_W   = $clog2(MUL_STEPS + 1);
    localparam int unsigned MSEL_W      = 2;

    // Offsets used to pack two coefficients into one word and to unpack them.
    localparam logic [WORD_W-1:0] FUV_BASE   = 64'h0000_0200_0000_0000;
    localparam logic [WORD_W-1:0] GRS_BASE   = 64'h4000_0000_0000_0000;
    localparam logic [WORD_W-1:0] EXT_HI_OFS = 64'h0000_0200_0010_0000;
    localparam logic [WORD_W-1:0] EXT_LO_OFS = 64'h0000_0000_0010_0000;

    // Multiplier step codes: which operand half and which term is multiplied.
    // They follow the order in which the controller's step counter issues them.
    localparam logic [MSEL_W-1:0] MSEL_A0_LO = 2'd0;
    localparam logic [MSEL_W-1:0] MSEL_A0_HI = 2'd1;
    localparam logic [MSEL_W-1:0] MSEL_A1_LO = 2'd2;
    localparam logic [MSEL_W-1:0] MSEL_A1_HI = 2'd3;

    typedef logic [WORD_W-1:0]         word_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic [MAT_W-1:0]          mat_t;
    typedef logic [DELTA_W-1:0]        delta_t;

    typedef struct packed {
        logic              load_item;
        logic              step;
        logic              extract;
        logic              acc_init;
        logic              mul_valid;
        logic [MSEL_W-1:0] mul_sel;
        logic              mode_cmp;
        logic              upd_wb;
        logic              cmp_wb;
        logic              out_load;
    } dp_cmd_t;

    // Low bits of f packed against the offset for the (u, v) word.
    function automatic word_t pack_f(input logic [LOW_W-1:0] low);
        return {{(WORD_W-LOW_W){1'b0}}, low} - FUV_BASE;
    endfunction

    // Low bits of g packed against the offset for the (r, s) word.
    function automatic word_t pack_g(input logic [LOW_W-1:0] low);
        return {{(WORD_W-LOW_W){1'b0}}, low} - GRS_BASE;
    endfunction

    // Arithmetic shift right by the round length.
    function automatic word_t sra_round(input word_t x);
        return {{LOW_W{x[WORD_W-1]}}, x[WORD_W-1:LOW_W]};
    endfunction

    // Upper coefficient of a packed word (v or s).
    function automatic coef_t ext_hi(input word_t x);
        word_t sum;
        sum = x + EXT_HI_OFS;
        return coef_t'(sum[WORD_W-1:WORD_W-COEF_W]);
    endfunction

    // Lower coefficient of a packed word (u or r), 21 bits sign-extended.
    function automatic coef_t ext_lo(input word_t x);
        word_t sum;
        sum = x + EXT_LO_OFS;
        return coef_t'({sum[41], sum[41:21]});
    endfunction

endpackage

// File: rtl/bdm_dot_lane.sv
// ----------------------------------------------------------------------------
// bdm_dot_lane
// One multiply-accumulate lane: a0*m0 + a1*m1 modulo 2^64, with 64-bit a
// operands and 22-bit signed coefficients, using one 33x22 multiplier over
// four steps and a registered product ahead of the accumulator.
// ----------------------------------------------------------------------------
module bdm_dot_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bdm_pkg::word_t                a0,
    input  bdm_pkg::word_t                a1,
    input  bdm_pkg::coef_t                m0,
    input  bdm_pkg::coef_t                m1,
    input  logic                          mul_valid,
    input  logic [bdm_pkg::MSEL_W-1:0]    mul_sel,
    output bdm_pkg::word_t                acc
);

    logic [32:0]                         op_u;
    logic signed [32:0]                  op_s;
    bdm_pkg::coef_t                      coef;
    logic signed [bdm_pkg::PROD_W-1:0]   prod_next;
    logic signed [bdm_pkg::PROD_W-1:0]   prod_reg;
    logic                                prod_hi_reg;
    logic                                prod_first_reg;
    logic                                prod_valid_reg;
    bdm_pkg::word_t                      contrib;
    bdm_pkg::word_t                      acc_reg;
    bdm_pkg::word_t                      acc_next;

    always_comb begin
        unique case (mul_sel)
            bdm_pkg::MSEL_A0_LO: begin
                op_u = {1'b0, a0[31:0]};
                coef = m0;
            end
            bdm_pkg::MSEL_A0_HI: begin
                op_u = {1'b0, a0[63:32]};
                coef = m0;
            end
            bdm_pkg::MSEL_A1_LO: begin
                op_u = {1'b0, a1[31:0]};
                coef = m1;
            end
            default: begin
                op_u = {1'b0, a1[63:32]};
                coef = m1;
            end
        endcase
        op_s      = $signed(op_u);
        prod_next = op_s * coef;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= mul_valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg       <= prod_next;
        prod_hi_reg    <= (mul_sel == bdm_pkg::MSEL_A0_HI) || (mul_sel == bdm_pkg::MSEL_A1_HI);
        prod_first_reg <= (mul_sel == bdm_pkg::MSEL_A0_LO);
    end

    // An upper-half product only reaches the top 32 bits of the result.
    always_comb begin
        if (prod_hi_reg) begin
            contrib = {prod_reg[31:0], 32'b0};
        end else begin
            contrib = {{(bdm_pkg::WORD_W-bdm_pkg::PROD_W){prod_reg[bdm_pkg::PROD_W-1]}},
                       prod_reg};
        end
        acc_next = (prod_first_reg ? '0 : acc_reg) + contrib;
    end

    always_ff @(posedge aclk) begin
        if (prod_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: rtl/bdm_datapath.sv
// ----------------------------------------------------------------------------
// bdm_datapath
// Packed divstep engine, coefficient unpacking, four multiply-accumulate
// lanes for the f/g update and matrix composition, and the result register.
// ----------------------------------------------------------------------------
module bdm_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bdm_pkg::dp_cmd_t            cmd,
    input  logic                        s_start_req,
    input  logic signed [63:0]          s_f_value,
    input  logic signed [63:0]          s_g_value,
    output logic signed [61:0]          m_mat_uu,
    output logic signed [61:0]          m_mat_vv,
    output logic signed [61:0]          m_mat_rr,
    output logic signed [61:0]          m_mat_ss,
    output logic signed [15:0]          m_delta_out
);

    bdm_pkg::word_t  f_reg;
    bdm_pkg::word_t  g_reg;
    bdm_pkg::word_t  fuv_reg;
    bdm_pkg::word_t  grs_reg;
    bdm_pkg::delta_t delta_reg;
    bdm_pkg::coef_t  m_reg   [4];
    bdm_pkg::mat_t   acc_reg [4];
    bdm_pkg::mat_t   out_mat_reg [4];
    bdm_pkg::delta_t out_delta_reg;

    bdm_pkg::delta_t delta_m1;
    logic            g_odd;
    logic            swap;
    bdm_pkg::word_t  addend;
    bdm_pkg::word_t  g_sum;
    bdm_pkg::word_t  fuv_next;
    bdm_pkg::word_t  grs_next;
    bdm_pkg::delta_t delta_next;

    bdm_pkg::coef_t  ex     [4];
    bdm_pkg::word_t  lane_a0 [4];
    bdm_pkg::word_t  lane_a1 [4];
    bdm_pkg::word_t  lane_acc [4];
    bdm_pkg::word_t  new_f;
    bdm_pkg::word_t  new_g;
    bdm_pkg::word_t  acc_ext [4];

    // One divstep on the packed words.
    always_comb begin
        delta_m1 = delta_reg - 16'd1;
        g_odd    = grs_reg[0];
        swap     = delta_m1[bdm_pkg::DELTA_W-1] & g_odd;
        if (swap) begin
            addend     = '0 - fuv_reg;
            fuv_next   = grs_reg;
            delta_next = '0 - delta_reg;
        end else begin
            addend     = g_odd ? fuv_reg : '0;
            fuv_next   = fuv_reg;
            delta_next = delta_m1;
        end
        g_sum    = grs_reg + addend;
        grs_next = {g_sum[bdm_pkg::WORD_W-1], g_sum[bdm_pkg::WORD_W-1:1]};
    end

    always_comb begin
        ex[0] = bdm_pkg::ext_lo(fuv_reg);
        ex[1] = bdm_pkg::ext_hi(fuv_reg);
        ex[2] = bdm_pkg::ext_lo(grs_reg);
        ex[3] = bdm_pkg::ext_hi(grs_reg);
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            acc_ext[k] = {{(bdm_pkg::WORD_W-bdm_pkg::MAT_W){1'b0}}, acc_reg[k]};
        end
        // Lanes 0 and 2 also serve the f/g update; lanes 1 and 3 compose only.
        lane_a0[0] = cmd.mode_cmp ? acc_ext[0] : f_reg;
        lane_a1[0] = cmd.mode_cmp ? acc_ext[2] : g_reg;
        lane_a0[1] = acc_ext[1];
        lane_a1[1] = acc_ext[3];
        lane_a0[2] = cmd.mode_cmp ? acc_ext[0] : f_reg;
        lane_a1[2] = cmd.mode_cmp ? acc_ext[2] : g_reg;
        lane_a0[3] = acc_ext[1];
        lane_a1[3] = acc_ext[3];
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        bdm_dot_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .a0        (lane_a0[k]),
            .a1        (lane_a1[k]),
            .m0        (m_reg[(k/2)*2]),
            .m1        (m_reg[(k/2)*2+1]),
            .mul_valid (cmd.mul_valid),
            .mul_sel   (cmd.mul_sel),
            .acc       (lane_acc[k])
        );
    end

    assign new_f = bdm_pkg::sra_round(lane_acc[0]);
    assign new_g = bdm_pkg::sra_round(lane_acc[2]);

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            f_reg   <= s_f_value;
            g_reg   <= s_g_value;
            fuv_reg <= bdm_pkg::pack_f(s_f_value[bdm_pkg::LOW_W-1:0]);
            grs_reg <= bdm_pkg::pack_g(s_g_value[bdm_pkg::LOW_W-1:0]);
        end else if (cmd.step) begin
            fuv_reg <= fuv_next;
            grs_reg <= grs_next;
        end else if (cmd.upd_wb) begin
            f_reg   <= new_f;
            g_reg   <= new_g;
            fuv_reg <= bdm_pkg::pack_f(new_f[bdm_pkg::LOW_W-1:0]);
            grs_reg <= bdm_pkg::pack_g(new_g[bdm_pkg::LOW_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_reg <= 16'd1;
        end else if (cmd.load_item) begin
            if (s_start_req) begin
                delta_reg <= 16'd1;
            end
        end else if (cmd.step) begin
            delta_reg <= delta_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 4; k++) begin
            if (cmd.extract) begin
                m_reg[k] <= ex[k];
            end
            if (cmd.acc_init) begin
                acc_reg[k] <= {{(bdm_pkg::MAT_W-bdm_pkg::COEF_W){ex[k][bdm_pkg::COEF_W-1]}},
                               ex[k]};
            end else if (cmd.cmp_wb) begin
                acc_reg[k] <= lane_acc[k][bdm_pkg::MAT_W-1:0];
            end
            if (cmd.out_load) begin
                out_mat_reg[k] <= acc_reg[k];
            end
        end
        if (cmd.out_load) begin
            out_delta_reg <= delta_reg;
        end
    end

    assign m_mat_uu    = out_mat_reg[0];
    assign m_mat_vv    = out_mat_reg[1];
    assign m_mat_rr    = out_mat_reg[2];
    assign m_mat_ss    = out_mat_reg[3];
    assign m_delta_out = out_delta_reg;

endmodule

// File: rtl/bdm_ctrl.sv
// ----------------------------------------------------------------------------
// bdm_ctrl
// Sequencer for the divstep unit: counts steps, rounds and multiplier
// steps, issues datapath commands and owns both channel handshakes.
// ----------------------------------------------------------------------------
module bdm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bdm_pkg::dp_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_STEP    = 3'd1;
    localparam logic [2:0] ST_EXTRACT = 3'd2;
    localparam logic [2:0] ST_MUL     = 3'd3;
    localparam logic [2:0] ST_UPD_WB  = 3'd4;
    localparam logic [2:0] ST_CMP_WB  = 3'd5;
    localparam logic [2:0] ST_FINISH  = 3'd6;

    localparam logic [bdm_pkg::STEP_CNT_W-1:0] STEP_LAST =
        bdm_pkg::STEP_CNT_W'(bdm_pkg::STEPS_PER_ROUND - 1);
    localparam logic [bdm_pkg::ROUND_CNT_W-1:0] ROUND_LAST =
        bdm_pkg::ROUND_CNT_W'(bdm_pkg::ROUNDS - 1);
    localparam logic [bdm_pkg::MUL_CNT_W-1:0] MUL_LAST =
        bdm_pkg::MUL_CNT_W'(bdm_pkg::MUL_STEPS);

    logic [2:0]                        state_reg,     state_next;
    logic [bdm_pkg::STEP_CNT_W-1:0]    step_cnt_reg,  step_cnt_next;
    logic [bdm_pkg::ROUND_CNT_W-1:0]   round_cnt_reg, round_cnt_next;
    logic [bdm_pkg::MUL_CNT_W-1:0]     mul_cnt_reg,   mul_cnt_next;
    logic                              mode_cmp_reg,  mode_cmp_next;
    logic                              m_valid_reg,   m_valid_next;

    always_comb begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        round_cnt_next = round_cnt_reg;
        mul_cnt_next   = mul_cnt_reg;
        mode_cmp_next  = mode_cmp_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd            = '0;
        cmd.mode_cmp   = mode_cmp_reg;
        cmd.mul_sel    = mul_cnt_reg[bdm_pkg::MSEL_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item  = 1'b1;
                    step_cnt_next  = '0;
                    round_cnt_next = '0;
                    state_next     = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                if (step_cnt_reg == STEP_LAST) begin
                    step_cnt_next = '0;
                    state_next    = ST_EXTRACT;
                end else begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            ST_EXTRACT: begin
                cmd.extract   = 1'b1;
                cmd.acc_init  = (round_cnt_reg == '0);
                mul_cnt_next  = '0;
                mode_cmp_next = (round_cnt_reg == ROUND_LAST);
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_valid = (mul_cnt_reg != MUL_LAST);
                if (mul_cnt_reg == MUL_LAST) begin
                    mul_cnt_next = '0;
                    state_next   = mode_cmp_reg ? ST_CMP_WB : ST_UPD_WB;
                end else begin
                    mul_cnt_next = mul_cnt_reg + 1'b1;
                end
            end
            ST_UPD_WB: begin
                cmd.upd_wb = 1'b1;
                if (round_cnt_reg == '0) begin
                    round_cnt_next = round_cnt_reg + 1'b1;
                    state_next     = ST_STEP;
                end else begin
                    mode_cmp_next = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_CMP_WB: begin
                cmd.cmp_wb = 1'b1;
                if (round_cnt_reg == ROUND_LAST) begin
                    state_next = ST_FINISH;
                end else begin
                    round_cnt_next = round_cnt_reg + 1'b1;
                    state_next     = ST_STEP;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            mul_cnt_reg   <= '0;
            mode_cmp_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            round_cnt_reg <= round_cnt_next;
            mul_cnt_reg   <= mul_cnt_next;
            mode_cmp_reg  <= mode_cmp_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: rtl/batched_divstep_matrix_unit.sv
// ----------------------------------------------------------------------------
// batched_divstep_matrix_unit
// Computes the 60-divstep transition matrix and the final delta from the
// low 64-bit words of f and g, in three rounds of 20 packed divsteps.
//
// An item enters as one beat on the s_ channel (valid/ready): a start flag
// and the low words of f and g. When the start flag is set, delta is forced
// to 1 before the item's divsteps; otherwise delta carries on from the
// previous item. Each item yields exactly one beat on the m_ channel with
// the four matrix entries, scaled 2^60, and the new delta.
//
// A new item is taken only once the previous item's result has been loaded
// into the output register. The pace is set by the divstep engine, which
// does one dependent step per cycle (60 in all), and by the four
// multiply-accumulate lanes, each built around a single 33x22 multiplier
// shared by the operand halves of each f/g update or matrix composition;
// four such passes are made per item.
//
// The result waits in an output register, so the block goes back to taking
// input while a stalled result is still held. If the receiver is still
// stalling when the next result is ready, the sequencer holds it back until
// the output register is free. Synchronous active-low reset empties the
// output register, returns the sequencer to idle and sets delta to 1.
// ----------------------------------------------------------------------------
module batched_divstep_matrix_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_start_req,
    input  logic signed [63:0]   s_f_value,
    input  logic signed [63:0]   s_g_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [61:0]   m_mat_uu,
    output logic signed [61:0]   m_mat_vv,
    output logic signed [61:0]   m_mat_rr,
    output logic signed [61:0]   m_mat_ss,
    output logic signed [15:0]   m_delta_out
);

    // Command bundle from the sequencer to the datapath.
    bdm_pkg::dp_cmd_t cmd;

    // The sequencer owns both handshakes and all the counters.
    bdm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath holds f, g, the packed words, delta, the running matrix
    // and the output register.
    bdm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_start_req (s_start_req),
        .s_f_value   (s_f_value),
        .s_g_value   (s_g_value),
        .m_mat_uu    (m_mat_uu),
        .m_mat_vv    (m_mat_vv),
        .m_mat_rr    (m_mat_rr),
        .m_mat_ss    (m_mat_ss),
        .m_delta_out (m_delta_out)
    );

endmodule

// File: rtl/bdm_checker.sv
// ----------------------------------------------------------------------------
// bdm_checker
// Port-level checks for the batched divstep matrix unit, bound to the top
// level.
// ----------------------------------------------------------------------------
module bdm_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [61:0]   m_mat_uu,
    input  logic signed [61:0]   m_mat_vv,
    input  logic signed [61:0]   m_mat_rr,
    input  logic signed [61:0]   m_mat_ss,
    input  logic signed [15:0]   m_delta_out
);

    // A stalled result beat stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mat_uu) && $stable(m_mat_vv)
            && $stable(m_mat_rr) && $stable(m_mat_ss) && $stable(m_delta_out))
        else $error("stalled result beat changed");

    // Once an item is taken, the block is busy with it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // A fresh result appears only as the sequencer returns to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result appeared while the block was still busy");

    // Reset leaves the block idle with no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

endmodule

bind batched_divstep_matrix_unit bdm_checker u_bdm_checker (.*);

// File: dv/batched_divstep_matrix_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batched_divstep_matrix_unit_tb
// Self-checking bench for the 60-divstep transition matrix unit. Each beat
// accepted on the s_ channel is run through a bit-exact software predictor,
// which keeps its own delta and queues the expected matrix and delta. Every
// beat on the m_ channel is checked, field by field, against the oldest
// entry. Both channels idle at random, and the receiver holds off for a long
// stretch once so that the unit backs up and stalls its input.
// ----------------------------------------------------------------------------
module batched_divstep_matrix_unit_tb;

    // Limits of the run. The unit takes no new beat while one is in progress;
    // even with every gap and stall at its longest the run stays well inside this.
    localparam int unsigned CYCLE_LIMIT      = 5_000_000;
    localparam int unsigned DRAIN_CYCLES     = 200;
    localparam int unsigned LONG_HOLD_CYCLES = 1500;
    localparam int unsigned WRAP_RUN_ITEMS   = 560;
    localparam int unsigned RANDOM_ITEMS     = 875;

    // One result beat, laid out as on the m_ channel.
    typedef struct packed {
        logic [61:0] uu;
        logic [61:0] vv;
        logic [61:0] rr;
        logic [61:0] ss;
        logic [15:0] delta;
    } divstep_result_t;

    // A 2x2 matrix held as four 64-bit words: u, v, r, s.
    typedef logic [3:0][63:0] quad_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the jump matrix of each accepted beat and checks
    // the result beats in order.
    // ------------------------------------------------------------------------
    class divstep_scoreboard;
        localparam logic [63:0] F_PACK_OFS = 64'h0000_0200_0000_0000;
        localparam logic [63:0] G_PACK_OFS = 64'h4000_0000_0000_0000;
        localparam logic [63:0] HI_ROUND   = 64'h0000_0200_0010_0000;
        localparam logic [63:0] LO_ROUND   = 64'h0000_0000_0010_0000;
        localparam int unsigned ROUND_STEPS = 20;

        logic [15:0]     delta_state;
        divstep_result_t pending_matrices[$];
        int unsigned     error_count;
        int unsigned     result_count;

        function new();
            delta_state  = 16'd1;
            error_count  = 0;
            result_count = 0;
        endfunction

        function logic [63:0] shift_right_signed(logic [63:0] x, int unsigned n);
            return $signed(x) >>> n;
        endfunction

        // Twenty packed divsteps on the low bits of f and g; updates delta.
        function quad_t round_matrix(logic [63:0] f, logic [63:0] g);
            logic [63:0] fuv;
            logic [63:0] grs;
            logic [63:0] addend;
            logic [15:0] delta_less_one;
            quad_t       m;
            fuv = {44'd0, f[19:0]} - F_PACK_OFS;
            grs = {44'd0, g[19:0]} - G_PACK_OFS;
            for (int i = 0; i < ROUND_STEPS; i++) begin
                delta_less_one = delta_state - 16'd1;
                if (delta_less_one[15] && grs[0]) begin
                    addend      = -fuv;
                    fuv         = grs;
                    delta_state = -delta_state;
                end else begin
                    addend      = grs[0] ? fuv : 64'd0;
                    delta_state = delta_less_one;
                end
                grs = shift_right_signed(grs + addend, 1);
            end
            m[1] = shift_right_signed(fuv + HI_ROUND, 42);
            m[0] = shift_right_signed((fuv + LO_ROUND) << 22, 43);
            m[3] = shift_right_signed(grs + HI_ROUND, 42);
            m[2] = shift_right_signed((grs + LO_ROUND) << 22, 43);
            return m;
        endfunction

        // Newer matrix m applied on the left of the running product a.
        function quad_t compose(quad_t m, quad_t a);
            quad_t r;
            r[0] = m[0] * a[0] + m[1] * a[2];
            r[1] = m[0] * a[1] + m[1] * a[3];
            r[2] = m[2] * a[0] + m[3] * a[2];
            r[3] = m[2] * a[1] + m[3] * a[3];
            return r;
        endfunction

        function void note_input(logic start, logic [63:0] f, logic [63:0] g);
            quad_t           acc;
            quad_t           m;
            logic [63:0]     nf;
            logic [63:0]     ng;
            divstep_result_t want;
            if (start) begin
                delta_state = 16'd1;
            end
            acc = round_matrix(f, g);
            nf  = shift_right_signed(f * acc[0] + g * acc[1], 20);
            ng  = shift_right_signed(f * acc[2] + g * acc[3], 20);
            m   = round_matrix(nf, ng);
            f   = shift_right_signed(nf * m[0] + ng * m[1], 20);
            g   = shift_right_signed(nf * m[2] + ng * m[3], 20);
            acc = compose(m, acc);
            m   = round_matrix(f, g);
            acc = compose(m, acc);
            want.uu    = acc[0][61:0];
            want.vv    = acc[1][61:0];
            want.rr    = acc[2][61:0];
            want.ss    = acc[3][61:0];
            want.delta = delta_state;
            pending_matrices.push_back(want);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("ERROR result beat %0d: %s got %h expected %h",
                     result_count, what, got, want);
            error_count++;
        endtask

        task compare_field(string what, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report_mismatch(what, got, want);
            end
        endtask

        task check_result(divstep_result_t got);
            divstep_result_t want;
            if (pending_matrices.size() == 0) begin
                report_mismatch("beat with nothing expected", got.delta, 64'd0);
            end else begin
                want = pending_matrices.pop_front();
                compare_field("mat_uu", got.uu, want.uu);
                compare_field("mat_vv", got.vv, want.vv);
                compare_field("mat_rr", got.rr, want.rr);
                compare_field("mat_ss", got.ss, want.ss);
                compare_field("delta_out", got.delta, want.delta);
            end
            result_count++;
        endtask

        function int unsigned outstanding();
            return pending_matrices.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the unit under test.
    // ------------------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_start_req;
    logic signed [63:0] s_f_value;
    logic signed [63:0] s_g_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [61:0] m_mat_uu;
    logic signed [61:0] m_mat_vv;
    logic signed [61:0] m_mat_rr;
    logic signed [61:0] m_mat_ss;
    logic signed [15:0] m_delta_out;

    divstep_scoreboard board = new();
    int unsigned       cycle_count;
    bit                long_hold_req;

    batched_divstep_matrix_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_req (s_start_req),
        .s_f_value   (s_f_value),
        .s_g_value   (s_g_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_mat_uu    (m_mat_uu),
        .m_mat_vv    (m_mat_vv),
        .m_mat_rr    (m_mat_rr),
        .m_mat_ss    (m_mat_ss),
        .m_delta_out (m_delta_out)
    );

    // 10 ns clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Gap lengths: half of them none, most of the rest short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(50, 200);
    endfunction

    // Offers one beat after an idle gap and returns at the edge where it is
    // taken. With no gap the next beat follows straight on, so valid is not
    // dropped between two beats.
    task automatic send_item(input int unsigned gap, input logic start,
                             input logic [63:0] f, input logic [63:0] g);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_req <= start;
        s_f_value   <= f;
        s_g_value   <= g;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Gap for the sender: none during the long receiver hold, so the unit
    // fills up, and none in the quiet stretches of the random part.
    function automatic int unsigned sender_gap(bit quiet);
        if (long_hold_req || quiet) begin
            return 0;
        end
        return pick_gap();
    endfunction

    // A random 64-bit word, now and then a small signed value instead.
    function automatic logic [63:0] random_word();
        if ($urandom_range(0, 9) == 0) begin
            return 64'($signed($urandom_range(0, 511)) - 256);
        end
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Monitors. Both sample at the rising edge, before any of this edge's
    // nonblocking updates, so they see exactly what the unit sees.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_input(s_start_req, s_f_value, s_g_value);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result({m_mat_uu, m_mat_vv, m_mat_rr, m_mat_ss, m_delta_out});
        end
    end

    // Watchdog: a run that goes on past the limit has hung.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Stalls at random, with quiet stretches where it always takes
    // the beat. When asked, it holds off for a long stretch on its own count
    // while the sender keeps offering beats.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int unsigned stall_left;
        bit          rx_quiet;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            rx_quiet = ((cycle_count / 3000) % 4) == 2;
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [63:0] f;
        logic [63:0] g;
        bit          quiet;
        cycle_count   = 0;
        long_hold_req = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_start_req   = 1'b0;
        s_f_value     = '0;
        s_g_value     = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats: trivial values, the extremes of f and g, all-ones
        // low words, alternating bit patterns, g odd at every step, and
        // beats that carry delta on without a start.
        send_item(pick_gap(), 1'b1, 64'd1, 64'd0);
        send_item(pick_gap(), 1'b0, 64'd1, 64'd1);
        send_item(pick_gap(), 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        send_item(pick_gap(), 1'b0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(pick_gap(), 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(pick_gap(), 1'b0, 64'd0, 64'd0);
        send_item(pick_gap(), 1'b1, 64'h0000_0000_000F_FFFF, 64'h0000_0000_000F_FFFF);
        send_item(pick_gap(), 1'b0, 64'hFFFF_FFFF_FFF0_0000, 64'h0000_0000_000F_FFFF);
        send_item(pick_gap(), 1'b1, 64'd3, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(pick_gap(), 1'b0, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
        send_item(pick_gap(), 1'b1, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(pick_gap(), 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
        for (int i = 0; i < 4; i++) begin
            send_item(pick_gap(), 1'b0, {$urandom, $urandom} | 64'd1, {$urandom, $urandom});
        end

        // Even-g run: with the low 60 bits of g clear, no step swaps, so
        // delta falls by 60 per beat until it wraps past -32768 to 32767.
        for (int i = 0; i < WRAP_RUN_ITEMS; i++) begin
            g = {4'($urandom), 60'd0};
            send_item(sender_gap(1'b0), i == 0, {$urandom, $urandom}, g);
        end

        // Random beats, mostly with f odd as in a real inversion, and starts
        // now and then. One long receiver hold falls early in this part.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 100) begin
                long_hold_req = 1'b1;
            end
            quiet = ((i / 150) % 4) == 3;
            f     = random_word();
            g     = random_word();
            if ($urandom_range(0, 4) != 0) begin
                f[0] = 1'b1;
            end
            send_item(sender_gap(quiet), $urandom_range(0, 7) == 0, f, g);
        end
        s_valid <= 1'b0;

        // Wait for every expected beat, then a little longer for strays.
        while (board.outstanding() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/bdm_pkg.sv
rtl/bdm_dot_lane.sv
rtl/bdm_datapath.sv
rtl/bdm_ctrl.sv
rtl/batched_divstep_matrix_unit.sv
rtl/bdm_checker.sv
dv/batched_divstep_matrix_unit_tb.sv
